// ===== rtl/core/c8ax_pkg.sv =====
// Shared types, operation codes and flag constants for the 8-bit register/ALU execute block.
// No dependencies; the ALU and top-level files in rtl/core import this package.
`timescale 1ns / 1ps
`default_nettype none

package c8ax_pkg;

    typedef enum logic [4:0] {
        CMD_ADC    = 5'd0,
        CMD_SBC    = 5'd1,
        CMD_INCMEM = 5'd2,
        CMD_DECMEM = 5'd3,
        CMD_INX    = 5'd4,
        CMD_DEX    = 5'd5,
        CMD_INY    = 5'd6,
        CMD_DEY    = 5'd7,
        CMD_LDA    = 5'd8,
        CMD_LDX    = 5'd9,
        CMD_LDY    = 5'd10,
        CMD_STA    = 5'd11,
        CMD_STX    = 5'd12,
        CMD_STY    = 5'd13,
        CMD_TAX    = 5'd14,
        CMD_TXA    = 5'd15,
        CMD_TAY    = 5'd16,
        CMD_TYA    = 5'd17,
        CMD_TSX    = 5'd18,
        CMD_TXS    = 5'd19,
        CMD_FLAGOP = 5'd20,
        CMD_PHA    = 5'd21,
        CMD_PHP    = 5'd22,
        CMD_PLA    = 5'd23,
        CMD_PLP    = 5'd24,
        CMD_BRTEST = 5'd25
    } t_cmd;

    // Architectural register file.
    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] xreg;
        logic [7:0] yreg;
        logic [7:0] sp;
        logic [7:0] status;
    } t_regs;

    // Per-beat side results that are not architectural state.
    typedef struct packed {
        logic [7:0] write_data;
        logic       write_enable;
        logic [8:0] stack_address;
        logic       branch_taken;
    } t_side;

    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    localparam logic [7:0] KEEP_NOT_NVZC   = 8'h3C;
    localparam logic [7:0] KEEP_NOT_NZ     = 8'h7D;
    localparam logic [7:0] PUSH_STATUS_SET = 8'h30;
    localparam logic       STACK_PAGE      = 1'b1;

    localparam logic [1:0] SEL_V_FLAGOP = 2'd2;

    // Clears N and Z in the status byte and sets them from a result byte.
    function automatic logic [7:0] f_set_nz(input logic [7:0] status, input logic [7:0] value);
        logic [7:0] nz;
        nz = (value & FLAG_N) | ((value == 8'h00) ? FLAG_Z : 8'h00);
        return (status & KEEP_NOT_NZ) | nz;
    endfunction

    // Flag chosen by opcode bits 7:6 for the set/clear operations.
    function automatic logic [7:0] f_flagop_mask(input logic [1:0] sel);
        logic [7:0] mask;
        case (sel)
            2'd0:    mask = FLAG_C;
            2'd1:    mask = FLAG_I;
            2'd2:    mask = FLAG_V;
            default: mask = FLAG_D;
        endcase
        return mask;
    endfunction

    // Flag chosen by opcode bits 7:6 for the branch condition.
    function automatic logic [7:0] f_branch_mask(input logic [1:0] sel);
        logic [7:0] mask;
        case (sel)
            2'd0:    mask = FLAG_N;
            2'd1:    mask = FLAG_V;
            2'd2:    mask = FLAG_C;
            default: mask = FLAG_Z;
        endcase
        return mask;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/c8ax_alu.sv =====
// Combinational execute logic: next register state and side results for one operation.
// Depends on c8ax_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c8ax_alu (
    input  c8ax_pkg::t_cmd  i_cmd,
    input  logic [7:0]      i_operand,
    input  logic [7:0]      i_opcode,
    input  c8ax_pkg::t_regs i_regs,
    output c8ax_pkg::t_regs o_regs,
    output c8ax_pkg::t_side o_side
);
    import c8ax_pkg::*;

    logic [7:0] addend;
    logic [8:0] sum;
    logic [7:0] sum_lo;
    logic [7:0] adc_status;
    logic [7:0] flag_mask;
    logic [7:0] branch_mask;
    logic [7:0] mem_inc;
    logic [7:0] mem_dec;
    logic       stack_push;

    // Subtract is add of the complemented operand with carry as not-borrow.
    assign addend = (i_cmd == CMD_SBC) ? ~i_operand : i_operand;
    assign sum    = {1'b0, i_regs.acc} + {1'b0, addend} + {8'h00, i_regs.status[0]};
    assign sum_lo = sum[7:0];

    always_comb begin
        adc_status = (i_regs.status & KEEP_NOT_NVZC) | (sum_lo & FLAG_N);
        if ((((i_regs.acc ^ sum_lo) & (addend ^ sum_lo)) & FLAG_N) != 8'h00) begin
            adc_status = adc_status | FLAG_V;
        end
        if (sum_lo == 8'h00) begin
            adc_status = adc_status | FLAG_Z;
        end
        if (sum[8]) begin
            adc_status = adc_status | FLAG_C;
        end
    end

    assign flag_mask   = f_flagop_mask(i_opcode[7:6]);
    assign branch_mask = f_branch_mask(i_opcode[7:6]);
    assign mem_inc     = i_operand + 8'd1;
    assign mem_dec     = i_operand - 8'd1;
    assign stack_push  = (i_cmd == CMD_PHA) || (i_cmd == CMD_PHP);

    always_comb begin
        o_regs              = i_regs;
        o_side.write_data   = 8'h00;
        o_side.write_enable = 1'b0;
        o_side.branch_taken = 1'b0;
        case (i_cmd)
            CMD_ADC, CMD_SBC: begin
                o_regs.acc    = sum_lo;
                o_regs.status = adc_status;
            end
            CMD_INCMEM: begin
                o_regs.status       = f_set_nz(i_regs.status, mem_inc);
                o_side.write_data   = mem_inc;
                o_side.write_enable = 1'b1;
            end
            CMD_DECMEM: begin
                o_regs.status       = f_set_nz(i_regs.status, mem_dec);
                o_side.write_data   = mem_dec;
                o_side.write_enable = 1'b1;
            end
            CMD_INX: begin
                o_regs.xreg   = i_regs.xreg + 8'd1;
                o_regs.status = f_set_nz(i_regs.status, o_regs.xreg);
            end
            CMD_DEX: begin
                o_regs.xreg   = i_regs.xreg - 8'd1;
                o_regs.status = f_set_nz(i_regs.status, o_regs.xreg);
            end
            CMD_INY: begin
                o_regs.yreg   = i_regs.yreg + 8'd1;
                o_regs.status = f_set_nz(i_regs.status, o_regs.yreg);
            end
            CMD_DEY: begin
                o_regs.yreg   = i_regs.yreg - 8'd1;
                o_regs.status = f_set_nz(i_regs.status, o_regs.yreg);
            end
            CMD_LDA: begin
                o_regs.acc    = i_operand;
                o_regs.status = f_set_nz(i_regs.status, i_operand);
            end
            CMD_LDX: begin
                o_regs.xreg   = i_operand;
                o_regs.status = f_set_nz(i_regs.status, i_operand);
            end
            CMD_LDY: begin
                o_regs.yreg   = i_operand;
                o_regs.status = f_set_nz(i_regs.status, i_operand);
            end
            CMD_STA: begin
                o_side.write_data   = i_regs.acc;
                o_side.write_enable = 1'b1;
            end
            CMD_STX: begin
                o_side.write_data   = i_regs.xreg;
                o_side.write_enable = 1'b1;
            end
            CMD_STY: begin
                o_side.write_data   = i_regs.yreg;
                o_side.write_enable = 1'b1;
            end
            CMD_TAX: begin
                o_regs.xreg   = i_regs.acc;
                o_regs.status = f_set_nz(i_regs.status, i_regs.acc);
            end
            CMD_TXA: begin
                o_regs.acc    = i_regs.xreg;
                o_regs.status = f_set_nz(i_regs.status, i_regs.xreg);
            end
            CMD_TAY: begin
                o_regs.yreg   = i_regs.acc;
                o_regs.status = f_set_nz(i_regs.status, i_regs.acc);
            end
            CMD_TYA: begin
                o_regs.acc    = i_regs.yreg;
                o_regs.status = f_set_nz(i_regs.status, i_regs.yreg);
            end
            CMD_TSX: begin
                o_regs.xreg   = i_regs.sp;
                o_regs.status = f_set_nz(i_regs.status, i_regs.sp);
            end
            CMD_TXS: begin
                o_regs.sp = i_regs.xreg;
            end
            CMD_FLAGOP: begin
                // The overflow flag can only be cleared.
                if (i_opcode[7:6] != SEL_V_FLAGOP && i_opcode[5]) begin
                    o_regs.status = i_regs.status | flag_mask;
                end else begin
                    o_regs.status = i_regs.status & ~flag_mask;
                end
            end
            CMD_PHA: begin
                o_regs.sp           = i_regs.sp - 8'd1;
                o_side.write_data   = i_regs.acc;
                o_side.write_enable = 1'b1;
            end
            CMD_PHP: begin
                o_regs.sp           = i_regs.sp - 8'd1;
                o_side.write_data   = i_regs.status | PUSH_STATUS_SET;
                o_side.write_enable = 1'b1;
            end
            CMD_PLA: begin
                o_regs.sp     = i_regs.sp + 8'd1;
                o_regs.acc    = i_operand;
                o_regs.status = f_set_nz(i_regs.status, i_operand);
            end
            CMD_PLP: begin
                o_regs.sp     = i_regs.sp + 8'd1;
                o_regs.status = i_operand;
            end
            CMD_BRTEST: begin
                o_side.branch_taken = ((i_regs.status & branch_mask) != 8'h00) == i_opcode[5];
            end
            default: begin
                o_regs = i_regs;
            end
        endcase
        // Pushes address the slot before the decrement; everything else shows the new pointer.
        o_side.stack_address = {STACK_PAGE, stack_push ? i_regs.sp : o_regs.sp};
    end

endmodule

`default_nettype wire

// ===== rtl/core/cpu8_register_alu_execute.sv =====
// Top level of the 8-bit register/ALU execute block: input register, register file, result register.
// Depends on c8ax_pkg and c8ax_alu.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Input channel: i_in_valid / o_in_ready with i_cmd, i_operand, i_opcode. Each beat is one
//   operation (arithmetic, inc/dec, load/store, transfer, flag op, push/pull, branch test).
//   Output channel: o_out_valid / i_out_ready with one result beat per input beat: write data
//   and enable, stack address, branch decision and A, X, Y, S, P after the operation.
//   An accepted beat passes the input register, then the result register, before it is offered.
//   Throughput: one beat per cycle while the output is not held. The input register feeds
//   the execute logic, which reads the register file; the register file and the result register
//   load on the same edge, so the next beat in the input register already sees the updated state.
//   Stall: while the output is held, the input register keeps one more beat, then o_in_ready
//   drops. o_in_ready depends combinationally on i_out_ready.
//   Reset (i_rst_n low, synchronous): A, X, Y, S and P go to zero and both pipeline registers
//   empty; any beat held in them is dropped.
module cpu8_register_alu_execute (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [4:0] i_cmd,
    input  logic [7:0] i_operand,
    input  logic [7:0] i_opcode,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_write_data,
    output logic       o_write_enable,
    output logic [8:0] o_stack_address,
    output logic       o_branch_taken,
    output logic [7:0] o_acc_out,
    output logic [7:0] o_xreg_out,
    output logic [7:0] o_yreg_out,
    output logic [7:0] o_sp_out,
    output logic [7:0] o_status_out
);
    import c8ax_pkg::*;

    logic       r_in_valid;
    t_cmd       r_cmd;
    logic [7:0] r_operand;
    logic [7:0] r_opcode;

    t_regs      r_regs;
    t_regs      n_regs;
    t_side      n_side;

    logic       r_out_valid;
    t_regs      r_out_regs;
    t_side      r_out_side;

    logic       exec_fire;

    assign exec_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || exec_fire;

    c8ax_alu u_alu (
        .i_cmd     (r_cmd),
        .i_operand (r_operand),
        .i_opcode  (r_opcode),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_side    (n_side)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_regs      <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (exec_fire) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd     <= t_cmd'(i_cmd);
            r_operand <= i_operand;
            r_opcode  <= i_opcode;
        end
        if (exec_fire) begin
            r_out_regs <= n_regs;
            r_out_side <= n_side;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_write_data    = r_out_side.write_data;
    assign o_write_enable  = r_out_side.write_enable;
    assign o_stack_address = r_out_side.stack_address;
    assign o_branch_taken  = r_out_side.branch_taken;
    assign o_acc_out       = r_out_regs.acc;
    assign o_xreg_out      = r_out_regs.xreg;
    assign o_yreg_out      = r_out_regs.yreg;
    assign o_sp_out        = r_out_regs.sp;
    assign o_status_out    = r_out_regs.status;

endmodule

`default_nettype wire

// ===== rtl/core/c8ax_checker.sv =====
// Port-level checker for the execute block, attached to the top level by a bind statement.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module c8ax_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_write_enable,
    input logic [8:0] o_stack_address,
    input logic       o_branch_taken,
    input logic [7:0] o_sp_out
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result beat offered right after reset");

    // A result beat that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Only a branch test can take a branch, and it never writes.
    a_branch_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_branch_taken |-> !o_write_enable)
        else $error("branch taken together with a write");

    // The stack address differs from the final pointer only for a push, one slot above it.
    a_push_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_stack_address[7:0] != o_sp_out)
        |-> o_write_enable && (o_stack_address[7:0] == o_sp_out + 8'd1))
        else $error("stack address inconsistent with stack pointer");

    // The block can always take a beat when its result register is empty.
    a_ready_when_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output");

endmodule

bind cpu8_register_alu_execute c8ax_checker u_c8ax_checker (.*);

`default_nettype wire
